@@ rtl/core/hrd_pkg.sv @@
// ----------------------------------------------------------------------------
// hrd_pkg
// Types, sizes and codes shared by the Huffman record decoder modules.
// ----------------------------------------------------------------------------
package hrd_pkg;

  localparam int MAX_NODES      = 512;
  localparam int MAX_TREE_DEPTH = 256;
  localparam int FIELD_COUNT    = 5;

  localparam int NODE_AW  = $clog2(MAX_NODES);
  localparam int STACK_AW = $clog2(MAX_TREE_DEPTH);
  localparam int DEPTH_W  = $clog2(MAX_TREE_DEPTH + 1);
  localparam int CNT_W    = $clog2(MAX_NODES + 1);
  localparam int FIELD_W  = 3;
  localparam int BITS_W   = 4;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_TREE   = 2'd1,
    ACT_STREAM = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_TEXT      = 3'd0,
    KIND_FIELD_END = 3'd1,
    KIND_REC_END   = 3'd2,
    KIND_HOUR      = 3'd3,
    KIND_MINUTE    = 3'd4,
    KIND_ERROR     = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PH_TEXT   = 2'd0,
    PH_HOUR   = 2'd1,
    PH_MINUTE = 2'd2,
    PH_SPARE  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_T_TOS,
    ST_T_PAR,
    ST_T_UPD,
    ST_WALK,
    ST_FLUSH
  } state_e;

  localparam logic [7:0] ERR_TREE_DONE = 8'd0;
  localparam logic [7:0] ERR_TREE_FULL = 8'd1;
  localparam logic [7:0] ERR_NO_TREE   = 8'd2;
  localparam logic [7:0] ERR_LEAF_ROOT = 8'd3;
  localparam logic [7:0] ERR_FIELD_OVF = 8'd4;

  localparam logic [7:0] SYM_INTERNAL   = 8'd0;
  localparam logic [7:0] SYM_RECORD_END = 8'd1;
  localparam logic [7:0] SYM_FIELD_END  = 8'd2;

  typedef struct packed {
    logic [7:0]         sym;
    logic [NODE_AW-1:0] left;
    logic [NODE_AW-1:0] right;
  } node_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         value;
    logic [FIELD_W-1:0] field;
  } result_t;

  typedef struct packed {
    logic               wr_en;
    logic [NODE_AW-1:0] wr_addr;
    node_t              wr_data;
    logic               rd_en;
    logic [NODE_AW-1:0] rd_addr;
  } node_req_t;

  typedef struct packed {
    logic                wr_en;
    logic [STACK_AW-1:0] wr_addr;
    logic [NODE_AW-1:0]  wr_data;
    logic                rd_en;
    logic [STACK_AW-1:0] rd_addr;
  } stack_req_t;

  typedef struct packed {
    logic idle;
    logic pend_valid;
  } core_status_t;

endpackage

@@ rtl/core/hrd_ram.sv @@
// ----------------------------------------------------------------------------
// hrd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/hrd_core.sv @@
// ----------------------------------------------------------------------------
// hrd_core
// Sequencer for tree building and bitwise decoding over the node and stack
// memories, with a one-entry result buffer that marks the last result.
// ----------------------------------------------------------------------------
module hrd_core
  import hrd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [7:0]          byte_value,
  input  logic                out_free,
  output logic                push,
  output result_t             push_res,
  output logic                push_last,
  output node_req_t           node_req,
  input  node_t               node_rd,
  output stack_req_t          stack_req,
  input  logic [NODE_AW-1:0]  stack_rd,
  output core_status_t        status
);

  localparam int DA_W = DEPTH_W + 1;

  state_e state, state_next;

  logic [CNT_W-1:0]   node_count;
  logic [DEPTH_W-1:0] stack_depth;
  logic               tree_ready;
  logic [NODE_AW-1:0] walk;
  logic [FIELD_W-1:0] current_field;
  phase_e             record_phase;
  logic [7:0]         root_sym;
  logic [NODE_AW-1:0] root_left;
  logic [NODE_AW-1:0] root_right;
  logic [7:0]         byte_reg;
  logic [NODE_AW-1:0] parent;
  node_t              pent;
  logic               left_set;
  logic [NODE_AW-1:0] nidx;
  logic [BITS_W-1:0]  bits_left;
  logic               arrived;
  logic               pend_valid;
  result_t            pend;

  action_e            act;
  logic               accept;
  logic               idle_emit;
  result_t            idle_res;
  logic               tree_full;

  logic               par_left_set;
  logic [DA_W-1:0]    depth_after;
  logic               overflow;
  node_t              upd;
  logic [DEPTH_W-1:0] depth_pop;
  logic [DEPTH_W-1:0] depth_final;
  logic [DEPTH_W-1:0] depth_m1;

  logic               sym_hit;
  logic [NODE_AW-1:0] ch_left;
  logic [NODE_AW-1:0] ch_right;
  logic [BITS_W-1:0]  bits_m1;
  logic               wbit;
  logic [NODE_AW-1:0] w_next;
  logic               field_last;
  result_t            w_res;
  logic               stall;
  logic               w_done;

  assign act       = action_e'(action);
  assign accept    = in_valid && (state == ST_IDLE);
  assign tree_full = node_count >= CNT_W'(MAX_NODES);
  assign depth_m1  = stack_depth - DEPTH_W'(1);

  // single results that are decided at acceptance
  always_comb begin
    idle_emit = 1'b0;
    idle_res  = '{kind: KIND_ERROR, value: ERR_TREE_DONE, field: '0};
    case (act)
      ACT_TREE: begin
        if (tree_ready) begin
          idle_emit = 1'b1;
        end else if (tree_full) begin
          idle_emit      = 1'b1;
          idle_res.value = ERR_TREE_FULL;
        end
      end
      ACT_STREAM: begin
        idle_emit = 1'b1;
        case (record_phase)
          PH_HOUR: begin
            idle_res = '{kind: KIND_HOUR, value: byte_value, field: '0};
          end
          PH_MINUTE: begin
            idle_res = '{kind: KIND_MINUTE, value: byte_value, field: '0};
          end
          default: begin
            if (!tree_ready) begin
              idle_res.value = ERR_NO_TREE;
            end else if (root_sym != SYM_INTERNAL) begin
              idle_res.value = ERR_LEAF_ROOT;
            end else begin
              idle_emit = 1'b0;
            end
          end
        endcase
      end
      default: begin
        idle_emit = 1'b0;
      end
    endcase
  end

  // tree insertion against the parent entry read back from memory
  assign par_left_set = node_rd.left != '0;
  assign depth_after  = DA_W'(stack_depth) - DA_W'(par_left_set)
                        + DA_W'(byte_reg == SYM_INTERNAL);
  assign overflow     = depth_after > DA_W'(MAX_TREE_DEPTH);
  assign depth_pop    = stack_depth - DEPTH_W'(left_set);
  assign depth_final  = depth_pop + DEPTH_W'(byte_reg == SYM_INTERNAL);

  always_comb begin
    upd = pent;
    if (left_set) begin
      upd.right = nidx;
    end else begin
      upd.left = nidx;
    end
  end

  // one step per cycle unless stalled; a leaf restarts at the cached root
  assign sym_hit  = arrived && (node_rd.sym != SYM_INTERNAL);
  assign ch_left  = sym_hit ? root_left : node_rd.left;
  assign ch_right = sym_hit ? root_right : node_rd.right;
  assign bits_m1  = bits_left - BITS_W'(1);
  assign wbit     = byte_reg[bits_m1[2:0]];
  assign w_next   = wbit ? ch_left : ch_right;
  assign field_last = (4'(current_field) + 4'd1) >= 4'(FIELD_COUNT);
  assign stall    = (state == ST_WALK) && sym_hit && pend_valid && !out_free;
  assign w_done   = (sym_hit && (node_rd.sym == SYM_RECORD_END)) || (bits_left == '0);

  always_comb begin
    case (node_rd.sym)
      SYM_RECORD_END: begin
        w_res = '{kind: KIND_REC_END, value: SYM_RECORD_END, field: current_field};
      end
      SYM_FIELD_END: begin
        if (field_last) begin
          w_res = '{kind: KIND_ERROR, value: ERR_FIELD_OVF, field: '0};
        end else begin
          w_res = '{kind: KIND_FIELD_END, value: SYM_FIELD_END, field: current_field};
        end
      end
      default: begin
        w_res = '{kind: KIND_TEXT, value: node_rd.sym, field: current_field};
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_TREE: begin
              if (idle_emit) begin
                state_next = ST_FLUSH;
              end else if (node_count != '0) begin
                state_next = ST_T_TOS;
              end
            end
            ACT_STREAM: begin
              state_next = idle_emit ? ST_FLUSH : ST_WALK;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_T_TOS: state_next = ST_T_PAR;
      ST_T_PAR: state_next = overflow ? ST_FLUSH : ST_T_UPD;
      ST_T_UPD: state_next = ST_IDLE;
      ST_WALK: begin
        if (!stall && w_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and memory requests
  always_comb begin
    in_ready  = (state == ST_IDLE);
    push      = 1'b0;
    push_res  = pend;
    push_last = 1'b0;
    node_req  = '0;
    stack_req = '0;
    case (state)
      ST_IDLE: begin
        if (accept && !idle_emit) begin
          if (act == ACT_TREE) begin
            if (node_count == '0) begin
              node_req.wr_en     = 1'b1;
              node_req.wr_addr   = '0;
              node_req.wr_data   = '{sym: byte_value, left: '0, right: '0};
              stack_req.wr_en    = (byte_value == SYM_INTERNAL);
              stack_req.wr_addr  = '0;
              stack_req.wr_data  = '0;
            end else begin
              stack_req.rd_en    = 1'b1;
              stack_req.rd_addr  = depth_m1[STACK_AW-1:0];
            end
          end else if (act == ACT_STREAM) begin
            node_req.rd_en   = 1'b1;
            node_req.rd_addr = walk;
          end
        end
      end
      ST_T_TOS: begin
        node_req.rd_en   = 1'b1;
        node_req.rd_addr = stack_rd;
      end
      ST_T_PAR: begin
        if (!overflow) begin
          node_req.wr_en   = 1'b1;
          node_req.wr_addr = node_count[NODE_AW-1:0];
          node_req.wr_data = '{sym: byte_reg, left: '0, right: '0};
        end
      end
      ST_T_UPD: begin
        node_req.wr_en    = 1'b1;
        node_req.wr_addr  = parent;
        node_req.wr_data  = upd;
        stack_req.wr_en   = (byte_reg == SYM_INTERNAL);
        stack_req.wr_addr = depth_pop[STACK_AW-1:0];
        stack_req.wr_data = nidx;
      end
      ST_WALK: begin
        push = sym_hit && pend_valid && out_free;
        if (!stall && !w_done) begin
          node_req.rd_en   = 1'b1;
          node_req.rd_addr = w_next;
        end
      end
      ST_FLUSH: begin
        push      = pend_valid && out_free;
        push_last = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign status = '{idle: in_ready, pend_valid: pend_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      node_count    <= '0;
      stack_depth   <= '0;
      tree_ready    <= 1'b0;
      walk          <= '0;
      current_field <= '0;
      record_phase  <= PH_TEXT;
      arrived       <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            byte_reg <= byte_value;
            if (idle_emit) begin
              pend       <= idle_res;
              pend_valid <= 1'b1;
            end
            case (act)
              ACT_CLEAR: begin
                node_count    <= '0;
                stack_depth   <= '0;
                tree_ready    <= 1'b0;
                walk          <= '0;
                current_field <= '0;
                record_phase  <= PH_TEXT;
              end
              ACT_TREE: begin
                if (!idle_emit && node_count == '0) begin
                  node_count <= CNT_W'(1);
                  root_sym   <= byte_value;
                  root_left  <= '0;
                  root_right <= '0;
                  if (byte_value == SYM_INTERNAL) begin
                    stack_depth <= DEPTH_W'(1);
                  end else begin
                    tree_ready <= 1'b1;
                  end
                end
              end
              ACT_STREAM: begin
                case (record_phase)
                  PH_HOUR: record_phase <= PH_MINUTE;
                  PH_MINUTE: begin
                    record_phase  <= PH_TEXT;
                    current_field <= '0;
                    walk          <= '0;
                  end
                  default: begin
                    bits_left <= BITS_W'(8);
                    arrived   <= 1'b0;
                  end
                endcase
              end
              default: begin
              end
            endcase
          end
        end
        ST_T_TOS: begin
          parent <= stack_rd;
        end
        ST_T_PAR: begin
          pent     <= node_rd;
          left_set <= par_left_set;
          if (overflow) begin
            pend       <= '{kind: KIND_ERROR, value: ERR_TREE_FULL, field: '0};
            pend_valid <= 1'b1;
          end else begin
            nidx       <= node_count[NODE_AW-1:0];
            node_count <= node_count + CNT_W'(1);
          end
        end
        ST_T_UPD: begin
          stack_depth <= depth_final;
          if (depth_final == '0) begin
            tree_ready <= 1'b1;
          end
          if (parent == '0) begin
            root_left  <= upd.left;
            root_right <= upd.right;
          end
        end
        ST_WALK: begin
          if (!stall) begin
            if (sym_hit) begin
              pend       <= w_res;
              pend_valid <= 1'b1;
              if (node_rd.sym == SYM_FIELD_END && !field_last) begin
                current_field <= current_field + FIELD_W'(1);
              end
              if (node_rd.sym == SYM_RECORD_END) begin
                record_phase <= PH_HOUR;
              end
            end
            if (w_done) begin
              if (sym_hit) begin
                walk <= '0;
              end
            end else begin
              walk      <= w_next;
              arrived   <= 1'b1;
              bits_left <= bits_m1;
            end
          end
        end
        ST_FLUSH: begin
          if (pend_valid && out_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/core/huffman_record_decoder.sv @@
// ----------------------------------------------------------------------------
// huffman_record_decoder
// Builds a Huffman tree from preorder bytes and decodes record streams.
// ----------------------------------------------------------------------------
// One item is taken at a time. A tree byte for the first node is written
// directly; any other tree byte goes through a stack read, a parent read
// and, unless the stack would overflow, a node write and a parent write. A
// stream byte in the text phase starts with a read of the walk node, then one
// read of the node table per bit, issued back to back from the registered
// read data, a check of the node reached by the last bit, and a final step
// that hands out the last result; a record end stops the walk early. Hour,
// minute and error bytes go straight to that final step. A walk at a symbol and the final
// step wait while the output register is full and not taken. Clear and unused actions give no result.
module huffman_record_decoder
  import hrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic [2:0] field_index,
  output logic       last
);

  node_req_t          node_req;
  stack_req_t         stack_req;
  logic [$bits(node_t)-1:0] node_rd_raw;
  node_t              node_rd;
  logic [NODE_AW-1:0] stack_rd;
  logic               out_free;
  logic               push;
  result_t            push_res;
  logic               push_last;
  core_status_t       status;

  assign node_rd  = node_t'(node_rd_raw);
  assign out_free = !out_valid || out_ready;

  hrd_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (node_req.wr_en),
    .wr_addr (node_req.wr_addr),
    .wr_data (node_req.wr_data),
    .rd_en   (node_req.rd_en),
    .rd_addr (node_req.rd_addr),
    .rd_data (node_rd_raw)
  );

  hrd_ram #(
    .WIDTH (NODE_AW),
    .DEPTH (MAX_TREE_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stack_req.wr_en),
    .wr_addr (stack_req.wr_addr),
    .wr_data (stack_req.wr_data),
    .rd_en   (stack_req.rd_en),
    .rd_addr (stack_req.rd_addr),
    .rd_data (stack_rd)
  );

  hrd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .byte_value (byte_value),
    .out_free   (out_free),
    .push       (push),
    .push_res   (push_res),
    .push_last  (push_last),
    .node_req   (node_req),
    .node_rd    (node_rd),
    .stack_req  (stack_req),
    .stack_rd   (stack_rd),
    .status     (status)
  );

  // output register: load on push, drop on transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind        <= push_res.kind;
      value       <= push_res.value;
      field_index <= push_res.field;
      last        <= push_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    status.idle |-> !status.pend_valid)
    else $error("core idle with a result still buffered");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_HOUR || kind == KIND_MINUTE) |-> last && field_index == '0)
    else $error("hour or minute result not marked last");

  a_end_values: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_FIELD_END |-> value == SYM_FIELD_END)
    else $error("field end result with wrong value");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed into a full output register");
`endif

endmodule
